@@ rtl/core/swrm_pkg.sv @@
package swrm_pkg;

	localparam int unsigned WINDOW_DEF   = 100;
	localparam logic [31:0] TICK_RESET   = 32'd100000000;
	localparam int unsigned TIME_W       = 48;
	localparam int unsigned LEN_W        = 16;
	localparam int unsigned BYTES_W      = 48;
	localparam int unsigned MSG_W        = 32;
	localparam int unsigned WBYTES_W     = 24;
	localparam int unsigned BRATE_W      = 40;
	localparam int unsigned MRATE_W      = 32;
	localparam int unsigned TICK_W       = 32;

	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_END  = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [LEN_W-1:0]  len;
	} cell_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_SETUP,
		MD_DIV
	} md_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT
	} st_t;

	typedef struct packed {
		logic start;
	} md_ctrl_t;

	typedef struct packed {
		logic done;
	} md_stat_t;

endpackage

@@ rtl/core/swrm_cell.sv @@
module swrm_cell (
	input  logic          clk,
	input  logic          shift,
	input  swrm_pkg::cell_t d,
	output swrm_pkg::cell_t q
);
	import swrm_pkg::*;

	cell_t data_q;

	// payload only, the valid window is tracked by the message count
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

@@ rtl/core/swrm_muldiv.sv @@
module swrm_muldiv #(
	parameter int unsigned A_W = 8,
	parameter int unsigned Q_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swrm_pkg::md_ctrl_t   ctrl,
	input  logic [A_W-1:0]       a,
	input  logic [31:0]          b,
	input  logic [47:0]          d,
	output swrm_pkg::md_stat_t   stat,
	output logic [Q_W-1:0]       q
);
	import swrm_pkg::*;

	localparam int unsigned P_W  = A_W + 32;
	localparam int unsigned HI_W = P_W - Q_W;
	localparam int unsigned C_W  = (HI_W > 48) ? HI_W : 48;
	localparam int unsigned CN_W = 6;

	md_state_t         state_q, state_d;
	logic [CN_W-1:0]   cnt_q;
	logic [A_W-1:0]    a_q;
	logic [47:0]       d_q;
	logic [P_W-1:0]    prod_q;
	logic [47:0]       rem_q;
	logic [Q_W-1:0]    q_q;
	logic              sat_q;
	logic              done_q;

	logic [A_W:0]      sum;
	logic [C_W-1:0]    hi_ext;
	logic [48:0]       trial;
	logic [48:0]       diff;
	logic              ge;

	assign sum    = {1'b0, prod_q[P_W-1:32]} + (prod_q[0] ? {1'b0, a_q} : '0);
	assign hi_ext = C_W'(prod_q[P_W-1:Q_W]);
	assign trial  = {rem_q, prod_q[Q_W-1]};
	assign ge     = trial >= {1'b0, d_q};
	assign diff   = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE:  if (ctrl.start) state_d = MD_MUL;
			MD_MUL:   if (cnt_q == CN_W'(31)) state_d = MD_SETUP;
			MD_SETUP: state_d = MD_DIV;
			MD_DIV:   if (cnt_q == CN_W'(Q_W - 1)) state_d = MD_IDLE;
			default:  state_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			case (state_q)
				MD_IDLE: begin
					cnt_q <= '0;
					if (ctrl.start) done_q <= 1'b0;
				end
				MD_MUL: cnt_q <= (cnt_q == CN_W'(31)) ? '0 : cnt_q + 1'b1;
				MD_SETUP: cnt_q <= '0;
				MD_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CN_W'(Q_W - 1)) done_q <= 1'b1;
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (ctrl.start) begin
					a_q    <= a;
					d_q    <= d;
					prod_q <= {{A_W{1'b0}}, b};
				end
			end
			MD_MUL: prod_q <= {sum, prod_q[31:1]};
			MD_SETUP: begin
				// a quotient of 2^Q_W or more shows as high part >= divisor
				sat_q <= hi_ext >= C_W'(d_q);
				rem_q <= hi_ext[47:0];
				q_q   <= '0;
			end
			MD_DIV: begin
				prod_q <= prod_q << 1;
				q_q    <= {q_q[Q_W-2:0], ge};
				if (ge) rem_q <= diff[47:0];
				else    rem_q <= trial[47:0];
			end
			default: ;
		endcase
	end

	assign stat.done = done_q;
	assign q         = sat_q ? '1 : q_q;

endmodule

@@ rtl/core/sliding_window_rate_meter_unit.sv @@
// sliding window throughput meter
// input stream: s_tuser = cmd (0 data, 2 end, others ignored), s_tdata = byte_length,
// arrival_time. a data transaction produces one result transaction on the master side;
// markers, end of stream and anything after end of stream produce none.
// the window is a chain of WINDOW cells that shifts by one on each data message; the
// oldest arrival and length fall out of the last cell.
// rates come from three serial multiply/divide units running side by side: a multiply built
// of shift-and-add then 40 (bit rates) or 32 (message rate) restoring divide steps.
// a data message starts all three units; its result is loaded once all are done.
// ignored items are taken without starting a calculation. one item is in work at a
// time; the next is accepted as soon as the result sits in the output register, even
// while the receiver stalls it. a stalled result holds until m_tready; the unit then
// waits in its last step before loading the next one.
// zero divisor spans give all-ones rates and set m_tuser.
// cfg_we/cfg_data write tick_rate_hz, reset value 100000000. arst_n clears counts,
// window sum, end-of-stream flag and the output valid; cell contents are don't care.
module sliding_window_rate_meter_unit #(
	parameter int unsigned WINDOW = swrm_pkg::WINDOW_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // byte_length[15:0], arrival_time[63:16]
	input  logic [1:0]   s_tuser,   // cmd[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// message_total[31:0], byte_total[79:32], elapsed_ticks[127:80],
	// overall_bits_per_sec[167:128], window_bytes[191:168],
	// window_bits_per_sec[231:192], window_msgs_per_sec[263:232]
	output logic [263:0] m_tdata,
	output logic [0:0]   m_tuser    // zero_span[0]
);
	import swrm_pkg::*;

	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	localparam int unsigned WS_W  = LEN_W + CNT_W;
	localparam int unsigned WX_W  = (WS_W > WBYTES_W) ? WS_W : WBYTES_W;

	st_t                  state_q, state_d;
	logic [TICK_W-1:0]    tick_q;
	logic [MSG_W-1:0]     msg_q;
	logic [BYTES_W-1:0]   byte_q;
	logic [WS_W-1:0]      wsum_q;
	logic                 finished_q;
	logic [TIME_W-1:0]    now_q;
	logic [TIME_W-1:0]    span_q;
	logic [WBYTES_W-1:0]  wbytes_q;
	logic [CNT_W-1:0]     count_q;
	logic                 zero_q;
	logic                 m_tvalid_q;
	logic [263:0]         m_tdata_q;
	logic                 m_tuser_q;

	logic                 acc;
	logic                 acc_data;
	logic [LEN_W-1:0]     in_len;
	logic [TIME_W-1:0]    in_now;
	logic [MSG_W-1:0]     msg_next;
	logic [BYTES_W:0]     byte_sum;
	logic [BYTES_W-1:0]   byte_next;
	logic                 more;
	logic [WS_W-1:0]      wsum_next;
	logic [WX_W-1:0]      wsum_ext;
	logic [TIME_W-1:0]    start_t;
	logic                 all_done;
	logic                 load;

	cell_t                chain [WINDOW];
	cell_t                new_cell;
	md_ctrl_t             md_ctrl;
	md_stat_t             st_ob, st_wb, st_wm;
	logic [BRATE_W-1:0]   q_ob, q_wb;
	logic [MRATE_W-1:0]   q_wm;

	assign in_len   = s_tdata[15:0];
	assign in_now   = s_tdata[63:16];
	assign s_tready = state_q == ST_IDLE;
	assign acc      = s_tvalid && s_tready;
	assign acc_data = acc && !finished_q && s_tuser == CMD_DATA;

	assign new_cell.arrival = in_now;
	assign new_cell.len     = in_len;

	for (genvar i = 0; i < WINDOW; i++) begin : g_chain
		if (i == 0) begin : g_head
			swrm_cell u_cell (.clk, .shift(acc_data), .d(new_cell), .q(chain[i]));
		end else begin : g_body
			swrm_cell u_cell (.clk, .shift(acc_data), .d(chain[i-1]), .q(chain[i]));
		end
	end

	assign msg_next  = (msg_q == '1) ? msg_q : msg_q + 1'b1;
	assign byte_sum  = {1'b0, byte_q} + (BYTES_W + 1)'(in_len);
	assign byte_next = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
	assign more      = msg_next > MSG_W'(WINDOW);
	// the last cell holds the message that leaves the window
	assign start_t   = more ? chain[WINDOW-1].arrival : '0;
	assign wsum_next = more ? wsum_q - WS_W'(chain[WINDOW-1].len) + WS_W'(in_len)
	                        : WS_W'(byte_next);
	assign wsum_ext  = WX_W'(wsum_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= TICK_RESET;
			msg_q      <= '0;
			byte_q     <= '0;
			wsum_q     <= '0;
			finished_q <= 1'b0;
		end else begin
			if (cfg_we) tick_q <= cfg_data;
			if (acc && !finished_q && s_tuser == CMD_END) finished_q <= 1'b1;
			if (acc_data) begin
				msg_q  <= msg_next;
				byte_q <= byte_next;
				wsum_q <= wsum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_data) begin
			now_q    <= in_now;
			span_q   <= in_now - start_t;
			wbytes_q <= (wsum_ext > WX_W'({WBYTES_W{1'b1}})) ? '1 : wsum_ext[WBYTES_W-1:0];
			count_q  <= more ? CNT_W'(WINDOW) : CNT_W'(msg_next);
			zero_q   <= in_now == '0 || in_now == start_t;
		end
	end

	assign md_ctrl.start = state_q == ST_START;

	swrm_muldiv #(.A_W(BYTES_W + 3), .Q_W(BRATE_W)) u_ob (
		.clk, .arst_n, .ctrl(md_ctrl), .a({byte_q, 3'b000}), .b(tick_q), .d(now_q),
		.stat(st_ob), .q(q_ob));
	swrm_muldiv #(.A_W(WBYTES_W + 3), .Q_W(BRATE_W)) u_wb (
		.clk, .arst_n, .ctrl(md_ctrl), .a({wbytes_q, 3'b000}), .b(tick_q), .d(span_q),
		.stat(st_wb), .q(q_wb));
	swrm_muldiv #(.A_W(CNT_W), .Q_W(MRATE_W)) u_wm (
		.clk, .arst_n, .ctrl(md_ctrl), .a(count_q), .b(tick_q), .d(span_q),
		.stat(st_wm), .q(q_wm));

	assign all_done = st_ob.done && st_wb.done && st_wm.done;
	assign load     = state_q == ST_WAIT && all_done && !m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (acc_data) state_d = ST_START;
			ST_START: state_d = ST_WAIT;
			ST_WAIT:  if (load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {q_wm, q_wb, wbytes_q, q_ob, now_q, byte_q, msg_q};
			m_tuser_q <= zero_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q) else $error("end of stream flag cleared");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !acc_data) else $error("window shifted during a calculation");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[167:128] == '1 || m_tdata[231:192] == '1))
		else $error("zero span without saturated rate");

	a_load_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_START |=> !all_done) else $error("divider done too early");

endmodule

@@ bench/swrm_checker.sv @@
module swrm_checker #(
	parameter int unsigned WINDOW = swrm_pkg::WINDOW_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [63:0]  s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [263:0] m_tdata,
	input  logic [0:0]   m_tuser,
	output int           fails,
	output int           pending,
	output int           checked
);
	import swrm_pkg::*;

	typedef struct packed {
		logic [MSG_W-1:0]    msgs;
		logic [BYTES_W-1:0]  bytes;
		logic [TIME_W-1:0]   elapsed;
		logic [BRATE_W-1:0]  overall_bps;
		logic [WBYTES_W-1:0] win_bytes;
		logic [BRATE_W-1:0]  win_bps;
		logic [MRATE_W-1:0]  win_mps;
		logic                zero_span;
	} rate_rec_t;

	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	rate_rec_t rate_q[$];

	logic [TIME_W-1:0]  arrival_hist[WINDOW];
	logic [LEN_W-1:0]   length_hist[WINDOW];
	int unsigned        hist_slot;
	logic [MSG_W-1:0]   msg_cnt;
	logic [BYTES_W-1:0] byte_cnt;
	logic [BYTES_W-1:0] win_sum;
	logic               stream_done;
	logic [TICK_W-1:0]  tick_hz;

	assign pending = rate_q.size();

	function automatic logic [BRATE_W-1:0] sat_quot(input logic [127:0] num,
			input logic [TIME_W-1:0] den, input logic [BRATE_W-1:0] ceiling);
		logic [127:0] q;
		q = num / {80'b0, den};
		return (q > {88'b0, ceiling}) ? ceiling : q[BRATE_W-1:0];
	endfunction

	task automatic predict_rates(input logic [1:0] cmd, input logic [LEN_W-1:0] len,
			input logic [TIME_W-1:0] now);
		rate_rec_t r;
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] span;
		logic [MSG_W-1:0] cnt;
		logic [127:0] tick_w;
		if (stream_done)
			return;
		if (cmd == CMD_END) begin
			stream_done = 1'b1;
			return;
		end
		if (cmd != CMD_DATA)
			return;
		if (msg_cnt != '1)
			msg_cnt++;
		byte_cnt = (byte_cnt > BYTES_MAX - len) ? BYTES_MAX : byte_cnt + len;
		if (msg_cnt > WINDOW) begin
			start = arrival_hist[hist_slot];
			win_sum = win_sum - length_hist[hist_slot] + len;
			cnt = WINDOW;
		end else begin
			start = '0;
			win_sum = byte_cnt;
			cnt = msg_cnt;
		end
		arrival_hist[hist_slot] = now;
		length_hist[hist_slot] = len;
		hist_slot = (hist_slot + 1) % WINDOW;
		span = now - start;
		tick_w = {96'b0, tick_hz};
		r.msgs = msg_cnt;
		r.bytes = byte_cnt;
		r.elapsed = now;
		r.win_bytes = (win_sum > 48'hFFFFFF) ? '1 : win_sum[WBYTES_W-1:0];
		r.zero_span = (now == 0) || (span == 0);
		r.overall_bps = (now == 0) ? '1 :
			sat_quot({77'b0, byte_cnt, 3'b0} * tick_w, now, '1);
		if (span == 0) begin
			r.win_bps = '1;
			r.win_mps = '1;
		end else begin
			r.win_bps = sat_quot({101'b0, r.win_bytes, 3'b0} * tick_w, span, '1);
			r.win_mps = MRATE_W'(sat_quot({96'b0, cnt} * tick_w, span,
				{8'b0, {MRATE_W{1'b1}}}));
		end
		rate_q.push_back(r);
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		fails++;
	endtask

	task automatic compare_result();
		rate_rec_t got;
		rate_rec_t want;
		got = {m_tdata[31:0], m_tdata[79:32], m_tdata[127:80], m_tdata[167:128],
			m_tdata[191:168], m_tdata[231:192], m_tdata[263:232], m_tuser[0]};
		if (rate_q.size() == 0) begin
			flag_mismatch("unexpected result transaction", 64'(got.msgs), 64'd0);
			return;
		end
		want = rate_q.pop_front();
		checked++;
		if (got.msgs != want.msgs)
			flag_mismatch("message_total", 64'(got.msgs), 64'(want.msgs));
		if (got.bytes != want.bytes)
			flag_mismatch("byte_total", 64'(got.bytes), 64'(want.bytes));
		if (got.elapsed != want.elapsed)
			flag_mismatch("elapsed_ticks", 64'(got.elapsed), 64'(want.elapsed));
		if (got.overall_bps != want.overall_bps)
			flag_mismatch("overall_bits_per_sec", 64'(got.overall_bps),
				64'(want.overall_bps));
		if (got.win_bytes != want.win_bytes)
			flag_mismatch("window_bytes", 64'(got.win_bytes), 64'(want.win_bytes));
		if (got.win_bps != want.win_bps)
			flag_mismatch("window_bits_per_sec", 64'(got.win_bps), 64'(want.win_bps));
		if (got.win_mps != want.win_mps)
			flag_mismatch("window_msgs_per_sec", 64'(got.win_mps), 64'(want.win_mps));
		if (got.zero_span != want.zero_span)
			flag_mismatch("zero_span", 64'(got.zero_span), 64'(want.zero_span));
	endtask

	initial begin
		fails = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q.delete();
			hist_slot = 0;
			msg_cnt = '0;
			byte_cnt = '0;
			win_sum = '0;
			stream_done = 1'b0;
			tick_hz = TICK_RESET;
		end else begin
			if (cfg_we)
				tick_hz = cfg_data;
			if (s_tvalid && s_tready)
				predict_rates(s_tuser, s_tdata[15:0], s_tdata[63:16]);
			if (m_tvalid && m_tready)
				compare_result();
		end
	end

endmodule

@@ bench/tb.sv @@
module tb;
	import swrm_pkg::*;

	localparam logic [1:0] CMD_MARK  = 2'd1;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1950;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 120;
	localparam int CALM_LO      = 40000;
	localparam int CALM_HI      = 60000;
	localparam int HOLD_LEN     = 600;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [31:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;   // byte_length[15:0], arrival_time[63:16]
	logic [1:0]   s_tuser = '0;   // cmd[1:0]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [263:0] m_tdata;        // message_total .. window_msgs_per_sec, low bits first
	logic [0:0]   m_tuser;        // zero_span[0]

	int fails;
	int pending;
	int checked;
	int cyc = 0;
	int hold_left = 0;
	int quiet = 0;
	int sent = 0;
	int tick_settings = 0;
	logic [TIME_W-1:0] now_tick = '0;

	always #4 clk = ~clk;

	sliding_window_rate_meter_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	swrm_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fails(fails), .pending(pending), .checked(checked)
	);

	// receiver: random stalls, two long hold-offs, one calm stretch
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == 20000 || cyc == 90000)
			hold_left <= HOLD_LEN;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
		if (hold_left > 0)
			m_tready <= 1'b0;
		else if (cyc >= CALM_LO && cyc < CALM_HI)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 99) >= 12);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [LEN_W-1:0] len,
			input logic [TIME_W-1:0] at);
		if (!(cyc >= CALM_LO && cyc < CALM_HI) && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {at, len};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// only when nothing is in flight; markers leave no result, so allow the latency
	task automatic set_tick(input logic [31:0] hz);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= hz;
		@(posedge clk);
		cfg_we <= 1'b0;
		tick_settings++;
	endtask

	task automatic random_item(input int idx);
		logic [1:0] cmd;
		logic [LEN_W-1:0] len;
		int r;
		r = $urandom_range(0, 99);
		cmd = (r < 85) ? CMD_DATA : ((r < 93) ? CMD_MARK : CMD_SPARE);
		r = $urandom_range(0, 99);
		len = (r < 10) ? '0 : ((r < 20) ? '1 : LEN_W'($urandom));
		// long runs of equal arrival give zero window spans
		if (idx % 500 >= 350 && idx % 500 < 480) begin
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70)
				now_tick = now_tick + TIME_W'($urandom_range(0, 5000));
			else if (r < 80)
				now_tick = now_tick;
			else if (r < 92)
				now_tick = now_tick + TIME_W'($urandom);
			else
				now_tick = TIME_W'({$urandom, $urandom} >> 16);
		end
		send_item(cmd, len, now_tick);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_tick(TICK_RESET);
		send_item(CMD_DATA, 16'd0, 48'd0);
		send_item(CMD_DATA, 16'hFFFF, 48'd0);
		send_item(CMD_MARK, 16'h1234, 48'd7);
		send_item(CMD_SPARE, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		send_item(CMD_DATA, 16'd1, 48'd1);
		send_item(CMD_DATA, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
		send_item(CMD_DATA, 16'hFFFF, 48'd5);
		send_item(CMD_DATA, 16'h8000, 48'h8000_0000_0000);

		set_tick(32'hFFFF_FFFF);
		send_item(CMD_DATA, 16'hFFFF, 48'd1);
		send_item(CMD_DATA, 16'hFFFF, 48'd2);
		send_item(CMD_DATA, 16'd0, 48'hFFFF_FFFF_FFFF);

		set_tick(32'd0);
		send_item(CMD_DATA, 16'hFFFF, 48'd3);
		send_item(CMD_DATA, 16'd100, 48'd0);

		set_tick(32'd1);
		send_item(CMD_DATA, 16'hFFFF, 48'd1);
		send_item(CMD_DATA, 16'h5555, 48'hAAAA_AAAA_AAAA);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 400 == 0) begin
				case ((i / 400) % 5)
					0: set_tick($urandom);
					1: set_tick(32'd1);
					2: set_tick(32'hFFFF_FFFF);
					3: set_tick(32'd0);
					default: set_tick($urandom_range(1000, 200000000));
				endcase
			end
			random_item(i);
		end

		// end of stream, then everything is ignored
		send_item(CMD_END, 16'h00FF, now_tick);
		send_item(CMD_DATA, 16'hFFFF, now_tick + TIME_W'(1));
		send_item(CMD_END, 16'd0, 48'd0);
		send_item(CMD_DATA, 16'd3, 48'd9);
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d input transactions over %0d tick settings,", sent,
			tick_settings);
		$display("with %0d rate results compared against prediction", checked);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
